FILE: hdl/dual_motor_sync_pid_defines.svh
// Assertion macros shared by the dual motor sync PID RTL
`ifndef DUAL_MOTOR_SYNC_PID_DEFINES_SVH
`define DUAL_MOTOR_SYNC_PID_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/dmsp_pkg.sv
// Types, widths and register codes for the dual motor sync PID block
package dmsp_pkg;

    localparam int POSITION_BITS      = 16;
    localparam int GAIN_W             = 16;
    localparam int LIMIT_W            = 15;
    localparam int SPEED_W            = 16;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 16;
    localparam int GAIN_FRACTION_BITS = 8;
    localparam int INTEGRAL_LIMIT     = 100;

    // error after sync compensation can reach about 1.5x full scale
    localparam int ERR_W  = POSITION_BITS + 2;
    localparam int DERR_W = ERR_W + 1;
    // widest product is gain times error difference, plus room for a 3-term sum
    localparam int SUM_W  = GAIN_W + 1 + DERR_W + 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_TARGET    = 3'd0,
        CFG_RIGHT_TARGET   = 3'd1,
        CFG_PROP_GAIN      = 3'd2,
        CFG_INTEG_GAIN     = 3'd3,
        CFG_DERIV_GAIN     = 3'd4,
        CFG_SPEED_LIMIT    = 3'd5,
        CFG_SYNC_THRESHOLD = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [POSITION_BITS-1:0] left_position;
        logic [POSITION_BITS-1:0] right_position;
    } t_in_item;

    typedef struct packed {
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
        logic                      sync_applied;
    } t_out_item;

    // stage load strobes shared by both lanes
    typedef struct packed {
        logic load_s2;
        logic load_s3;
        logic load_s4;
    } t_lane_ctrl;

endpackage

FILE: hdl/dmsp_lane.sv
// One motor's PID lane: integral/derivative state, gain products, scaled sum
`include "dual_motor_sync_pid_defines.svh"

module dmsp_lane
    import dmsp_pkg::*;
#(
    parameter int GAIN_FRACTION_BITS = dmsp_pkg::GAIN_FRACTION_BITS,
    parameter int INTEGRAL_LIMIT     = dmsp_pkg::INTEGRAL_LIMIT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_lane_ctrl              i_ctrl,
    input  logic signed [ERR_W-1:0] i_err,
    input  logic [GAIN_W-1:0]       i_prop_gain,
    input  logic [GAIN_W-1:0]       i_integ_gain,
    input  logic [GAIN_W-1:0]       i_deriv_gain,
    output logic signed [SUM_W-1:0] o_quot
);

    localparam int INT_W = $clog2(INTEGRAL_LIMIT + 1) + 1;
    localparam int ACC_W = ERR_W + 1;
    localparam int PP_W  = GAIN_W + 1 + ERR_W;
    localparam int PI_W  = GAIN_W + 1 + INT_W;
    localparam int PD_W  = GAIN_W + 1 + DERR_W;

    localparam logic signed [ACC_W-1:0] LIM_POS = ACC_W'(INTEGRAL_LIMIT);
    localparam logic signed [ACC_W-1:0] LIM_NEG = -ACC_W'(INTEGRAL_LIMIT);
    localparam logic signed [SUM_W-1:0] RND     =
        SUM_W'((64'sd1 <<< GAIN_FRACTION_BITS) - 64'sd1);

    logic signed [INT_W-1:0]  r_integ;
    logic signed [ERR_W-1:0]  r_prev;
    logic signed [ACC_W-1:0]  acc;
    logic signed [INT_W-1:0]  n_integ;
    logic signed [DERR_W-1:0] derr;

    logic signed [ERR_W-1:0]  r_err_s2;
    logic signed [INT_W-1:0]  r_acc_s2;
    logic signed [DERR_W-1:0] r_derr_s2;

    logic signed [PP_W-1:0]   r_pp;
    logic signed [PI_W-1:0]   r_pi;
    logic signed [PD_W-1:0]   r_pd;

    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  biased;
    logic signed [SUM_W-1:0]  r_quot;

    always_comb begin
        acc = ACC_W'(r_integ) + ACC_W'(i_err);
        if (acc > LIM_POS) begin
            n_integ = INT_W'(LIM_POS);
        end else if (acc < LIM_NEG) begin
            n_integ = INT_W'(LIM_NEG);
        end else begin
            n_integ = INT_W'(acc);
        end
        derr = DERR_W'(i_err) - DERR_W'(r_prev);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else if (i_ctrl.load_s2) begin
            r_integ <= n_integ;
            r_prev  <= i_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_s2) begin
            r_err_s2  <= i_err;
            r_acc_s2  <= n_integ;
            r_derr_s2 <= derr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_s3) begin
            r_pp <= $signed({1'b0, i_prop_gain})  * r_err_s2;
            r_pi <= $signed({1'b0, i_integ_gain}) * r_acc_s2;
            r_pd <= $signed({1'b0, i_deriv_gain}) * r_derr_s2;
        end
    end

    // divide by 2^F truncating toward zero: bias negatives before the shift
    always_comb begin
        sum    = SUM_W'(r_pp) + SUM_W'(r_pi) + SUM_W'(r_pd);
        biased = sum + (sum[SUM_W-1] ? RND : '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_s4) begin
            r_quot <= biased >>> GAIN_FRACTION_BITS;
        end
    end

    assign o_quot = r_quot;

    `ASSERT_IMP(a_integ_bound, 1'b1,
        (ACC_W'(r_integ) <= LIM_POS) && (ACC_W'(r_integ) >= LIM_NEG),
        "integral left its clamp range")

endmodule

FILE: hdl/dmsp_merge.sv
// Output stage: saturates both lane results to the speed limit and holds the result
`include "dual_motor_sync_pid_defines.svh"

module dmsp_merge
    import dmsp_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic signed [SUM_W-1:0] i_left_quot,
    input  logic signed [SUM_W-1:0] i_right_quot,
    input  logic                    i_sync,
    input  logic [LIMIT_W-1:0]      i_speed_limit,
    output t_out_item               o_data
);

    logic signed [SUM_W-1:0] lim_pos;
    logic signed [SUM_W-1:0] lim_neg;
    t_out_item               n_data;
    t_out_item               r_data;

    function automatic logic signed [SPEED_W-1:0] sat(
        input logic signed [SUM_W-1:0] val,
        input logic signed [SUM_W-1:0] hi,
        input logic signed [SUM_W-1:0] lo
    );
        logic signed [SUM_W-1:0] res;
        if (val > hi) begin
            res = hi;
        end else if (val < lo) begin
            res = lo;
        end else begin
            res = val;
        end
        return SPEED_W'(res);
    endfunction

    always_comb begin
        lim_pos             = $signed(SUM_W'(i_speed_limit));
        lim_neg             = -lim_pos;
        n_data.left_speed   = sat(i_left_quot, lim_pos, lim_neg);
        n_data.right_speed  = sat(i_right_quot, lim_pos, lim_neg);
        n_data.sync_applied = i_sync;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

    `ASSERT_NXT(a_left_in_limit, i_load,
        ($signed(r_data.left_speed) <= $signed({1'b0, $past(i_speed_limit)})) &&
        ($signed(r_data.left_speed) >= -$signed({1'b0, $past(i_speed_limit)})),
        "left speed beyond limit")

endmodule

FILE: hdl/dual_motor_sync_pid.sv
// Dual motor sync PID top level: config registers, error front end, pipeline control
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one control tick:
//   both encoder positions. Output channel (o_out_valid / i_out_stall / o_out_data)
//   returns one transaction per tick: left and right speed plus the sync flag.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data, one per cycle;
//   unknown indexes are ignored. The user must write only while no tick is in flight (unenforced).
// Timing:
//   Five register stages: error front end, integral/derivative update, gain
//   multipliers, scaled sum, saturation into the output register. One tick is
//   accepted every cycle unless all stages are full and the output stalls; the integral
//   and last-error registers update once per tick, so ticks stream back to back.
// Reset:
//   Synchronous active-low reset empties the pipeline, clears integral and
//   last-error state, and loads the register defaults.
// Stall:
//   Each stage holds while the one after it is full and stalled; bubbles fill up
//   first, so o_in_stall rises only when all five stages hold data.
`include "dual_motor_sync_pid_defines.svh"

module dual_motor_sync_pid
    import dmsp_pkg::*;
#(
    parameter int GAIN_FRACTION_BITS = dmsp_pkg::GAIN_FRACTION_BITS,
    parameter int INTEGRAL_LIMIT     = dmsp_pkg::INTEGRAL_LIMIT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [POSITION_BITS-1:0] r_left_target;
    logic [POSITION_BITS-1:0] r_right_target;
    logic [GAIN_W-1:0]        r_prop_gain;
    logic [GAIN_W-1:0]        r_integ_gain;
    logic [GAIN_W-1:0]        r_deriv_gain;
    logic [LIMIT_W-1:0]       r_speed_limit;
    logic [CFG_DATA_W-1:0]    r_sync_threshold;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;
    logic load1, load5;
    t_lane_ctrl lane_ctrl;

    logic [POSITION_BITS:0]   target_sum;
    logic signed [ERR_W-1:0]  mid;
    logic signed [ERR_W-1:0]  lpos;
    logic signed [ERR_W-1:0]  rpos;
    logic signed [ERR_W-1:0]  diff;
    logic signed [ERR_W-1:0]  mag;
    logic signed [ERR_W-1:0]  half;
    logic                     sync;
    logic signed [ERR_W-1:0]  n_lerr;
    logic signed [ERR_W-1:0]  n_rerr;

    logic signed [ERR_W-1:0]  r_lerr;
    logic signed [ERR_W-1:0]  r_rerr;
    logic                     r_sync1, r_sync2, r_sync3, r_sync4;

    logic signed [SUM_W-1:0]  left_quot;
    logic signed [SUM_W-1:0]  right_quot;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_target    <= '0;
            r_right_target   <= '0;
            r_prop_gain      <= GAIN_W'(256);
            r_integ_gain     <= '0;
            r_deriv_gain     <= '0;
            r_speed_limit    <= LIMIT_W'(255);
            r_sync_threshold <= CFG_DATA_W'(10);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_LEFT_TARGET:    r_left_target    <= i_cfg_data[POSITION_BITS-1:0];
                CFG_RIGHT_TARGET:   r_right_target   <= i_cfg_data[POSITION_BITS-1:0];
                CFG_PROP_GAIN:      r_prop_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:     r_integ_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:     r_deriv_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_SPEED_LIMIT:    r_speed_limit    <= i_cfg_data[LIMIT_W-1:0];
                CFG_SYNC_THRESHOLD: r_sync_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline flow: a stage takes new data when empty or when it empties this cycle
    always_comb begin
        rdy5              = !r_v5 || !i_out_stall;
        rdy4              = !r_v4 || rdy5;
        rdy3              = !r_v3 || rdy4;
        rdy2              = !r_v2 || rdy3;
        rdy1              = !r_v1 || rdy2;
        load1             = i_in_valid && rdy1;
        lane_ctrl.load_s2 = r_v1 && rdy2;
        lane_ctrl.load_s3 = r_v2 && rdy3;
        lane_ctrl.load_s4 = r_v3 && rdy4;
        load5             = r_v4 && rdy5;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_in_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
            if (rdy5) r_v5 <= r_v4;
        end
    end

    // front end: common target, per-motor error and cross-coupling term
    always_comb begin
        target_sum = {1'b0, r_left_target} + {1'b0, r_right_target};
        mid        = $signed(ERR_W'(target_sum[POSITION_BITS:1]));
        lpos       = $signed(ERR_W'(i_in_data.left_position));
        rpos       = $signed(ERR_W'(i_in_data.right_position));
        diff       = lpos - rpos;
        mag        = diff[ERR_W-1] ? -diff : diff;
        sync       = mag > $signed(ERR_W'(r_sync_threshold));
        // halve toward zero: add one to negatives before the shift
        half       = (diff + $signed(ERR_W'(diff[ERR_W-1]))) >>> 1;
        n_lerr     = mid - lpos;
        n_rerr     = mid - rpos;
        if (sync) begin
            n_lerr = n_lerr - half;
            n_rerr = n_rerr + half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load1) begin
            r_lerr  <= n_lerr;
            r_rerr  <= n_rerr;
            r_sync1 <= sync;
        end
        if (lane_ctrl.load_s2) r_sync2 <= r_sync1;
        if (lane_ctrl.load_s3) r_sync3 <= r_sync2;
        if (lane_ctrl.load_s4) r_sync4 <= r_sync3;
    end

    dmsp_lane #(
        .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS),
        .INTEGRAL_LIMIT    (INTEGRAL_LIMIT)
    ) u_left_lane (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (lane_ctrl),
        .i_err        (r_lerr),
        .i_prop_gain  (r_prop_gain),
        .i_integ_gain (r_integ_gain),
        .i_deriv_gain (r_deriv_gain),
        .o_quot       (left_quot)
    );

    dmsp_lane #(
        .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS),
        .INTEGRAL_LIMIT    (INTEGRAL_LIMIT)
    ) u_right_lane (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (lane_ctrl),
        .i_err        (r_rerr),
        .i_prop_gain  (r_prop_gain),
        .i_integ_gain (r_integ_gain),
        .i_deriv_gain (r_deriv_gain),
        .o_quot       (right_quot)
    );

    dmsp_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (load5),
        .i_left_quot   (left_quot),
        .i_right_quot  (right_quot),
        .i_sync        (r_sync4),
        .i_speed_limit (r_speed_limit),
        .o_data        (o_out_data)
    );

    assign o_in_stall  = !rdy1;
    assign o_out_valid = r_v5;

    `ASSERT_IMP(a_stall_only_when_full, o_in_stall,
        r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && i_out_stall,
        "input stalled with room in the pipeline")
    `ASSERT_NXT(a_accept_fills_front, i_in_valid && !o_in_stall, r_v1,
        "accepted transaction not in front stage")
    `ASSERT_NXT(a_drain_empties_out, o_out_valid && !i_out_stall && !r_v4, !o_out_valid,
        "output still valid after last transaction taken")

endmodule
